// File: design/ale_pkg.sv
`timescale 1ns / 1ps

package ale_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_TAG    = 2'd1,
    PH_TITLE  = 2'd2,
    PH_WAIT   = 2'd3
  } ale_phase_e;

  typedef enum logic [1:0] {
    KIND_URL   = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_END   = 2'd3
  } ale_kind_e;

  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChA     = 8'h61;  // 'a'
  localparam logic [7:0] ChH     = 8'h68;  // 'h'
  localparam logic [7:0] ChSq    = 8'h27;  // single quote
  localparam logic [7:0] ChDq    = 8'h22;  // double quote

  localparam logic [2:0] HrefLen = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } ale_in_t;

  typedef struct packed {
    ale_kind_e  out_kind;
    logic [7:0] out_byte;
    logic       link_abandoned;
    logic       run_last;
  } ale_out_t;

  // classified work for one input byte
  typedef struct packed {
    logic       has_main;
    ale_kind_e  main_kind;
    logic [7:0] main_byte;
    logic       has_end;
    logic       abandoned;
  } ale_work_t;

  function automatic logic [7:0] ale_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // characters of "href="
  function automatic logic [7:0] ale_href_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h66;
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

endpackage

// File: design/ale_front.sv
`timescale 1ns / 1ps

module ale_front import ale_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ale_in_t   in_i,
  input  logic      q_full_i,
  output logic      wr_en_o,
  output ale_work_t wr_data_o
);

  ale_phase_e phase_q, phase_d;
  logic [1:0] open_q, open_d;
  logic [2:0] href_q, href_d;
  logic [1:0] close_q, close_d;
  logic       coll_q, coll_d;
  logic       fin_q, fin_d;

  logic       accept;
  logic [7:0] b, lb;
  logic [2:0] c;
  logic       closed;
  ale_work_t  work;

  assign accept = push_i && !q_full_i;
  assign b      = in_i.data_byte;
  assign lb     = ale_lower(in_i.data_byte);

  always_comb begin
    phase_d = phase_q;
    open_d  = open_q;
    href_d  = href_q;
    close_d = close_q;
    coll_d  = coll_q;
    fin_d   = fin_q;
    closed  = 1'b0;
    c       = 3'd0;
    work    = '0;
    work.main_kind = KIND_URL;

    if (phase_q == PH_SEARCH) begin
      if (open_q == 2'd0) begin
        open_d = (b == ChLt) ? 2'd1 : 2'd0;
      end else if (open_q == 2'd1) begin
        if (lb == ChA) open_d = 2'd2;
        else open_d = (b == ChLt) ? 2'd1 : 2'd0;
      end else begin
        if (b == ChSpace) begin
          phase_d = PH_TAG;
          open_d  = 2'd0;
          href_d  = 3'd0;
          close_d = 2'd0;
          coll_d  = 1'b0;
          fin_d   = 1'b0;
        end else begin
          open_d = (b == ChLt) ? 2'd1 : 2'd0;
        end
      end
    end else begin
      if (close_q == 2'd2 && b == ChGt) closed = 1'b1;
      else if (close_q == 2'd1 && lb == ChA) close_d = 2'd2;
      else close_d = (b == ChSlash) ? 2'd1 : 2'd0;

      if (closed) begin
        work.has_main  = 1'b1;
        work.main_kind = KIND_DONE;
        phase_d = PH_SEARCH;
        open_d  = 2'd0;
        href_d  = 3'd0;
        close_d = 2'd0;
        coll_d  = 1'b0;
        fin_d   = 1'b0;
      end else if (phase_q == PH_TAG) begin
        if (coll_q) begin
          if (b == ChSpace || b == ChGt) begin
            coll_d = 1'b0;
            fin_d  = 1'b1;
          end else if (b != ChSq && b != ChDq) begin
            work.has_main  = 1'b1;
            work.main_kind = KIND_URL;
            work.main_byte = b;
          end
        end else if (!fin_q) begin
          c = (href_q >= HrefLen) ? 3'd0 : href_q;
          if (lb == ale_href_char(c)) begin
            c = c + 3'd1;
            if (c == HrefLen) begin
              coll_d = 1'b1;
              c      = 3'd0;
            end
          end else begin
            c = (lb == ChH) ? 3'd1 : 3'd0;
          end
          href_d = c;
        end
        if (b == ChGt) begin
          phase_d = PH_TITLE;
          coll_d  = 1'b0;
          fin_d   = 1'b1;
          href_d  = 3'd0;
        end
      end else if (phase_q == PH_TITLE) begin
        if (b == ChLt) begin
          phase_d = PH_WAIT;
        end else begin
          work.has_main  = 1'b1;
          work.main_kind = KIND_TITLE;
          work.main_byte = b;
        end
      end
    end

    if (in_i.chunk_last) begin
      work.has_end   = 1'b1;
      work.abandoned = (phase_d != PH_SEARCH);
      phase_d = PH_SEARCH;
      open_d  = 2'd0;
      href_d  = 3'd0;
      close_d = 2'd0;
      coll_d  = 1'b0;
      fin_d   = 1'b0;
    end
  end

  assign wr_en_o   = accept && (work.has_main || work.has_end);
  assign wr_data_o = work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      open_q  <= 2'd0;
      href_q  <= 3'd0;
      close_q <= 2'd0;
      coll_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      open_q  <= open_d;
      href_q  <= href_d;
      close_q <= close_d;
      coll_q  <= coll_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// File: design/ale_queue.sv
`timescale 1ns / 1ps

module ale_queue import ale_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  ale_work_t wr_data_i,
  input  logic      rd_en_i,
  output ale_work_t rd_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ale_work_t       entries_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (do_rd) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: design/ale_back.sv
`timescale 1ns / 1ps

module ale_back import ale_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ale_work_t head_i,
  input  logic      q_empty_i,
  output logic      deq_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ale_out_t  out_o
);

  logic     valid_q, valid_d;
  logic     half_q, half_d;
  ale_out_t out_q, out_d;
  logic     load;

  assign load = !valid_q || pop_i;

  always_comb begin
    deq_o   = 1'b0;
    half_d  = half_q;
    valid_d = valid_q && !pop_i;
    out_d   = out_q;
    if (load && !q_empty_i) begin
      valid_d = 1'b1;
      if (head_i.has_main && !half_q) begin
        out_d.out_kind       = head_i.main_kind;
        out_d.out_byte       = head_i.main_byte;
        out_d.link_abandoned = 1'b0;
        out_d.run_last       = !head_i.has_end;
        if (head_i.has_end) half_d = 1'b1;
        else deq_o = 1'b1;
      end else begin
        // chunk end marker
        out_d.out_kind       = KIND_END;
        out_d.out_byte       = 8'd0;
        out_d.link_abandoned = head_i.abandoned;
        out_d.run_last       = 1'b1;
        deq_o  = 1'b1;
        half_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !valid_q;
  assign out_o   = out_q;

endmodule

// File: design/anchor_link_extractor.sv
`timescale 1ns / 1ps

// Anchor link extractor: takes one byte of an HTML chunk per clock and pulls
// out anchor links. Each link yields its url bytes (kind 0, quotes dropped),
// its title bytes (kind 1) and a link-complete marker (kind 2); the byte
// flagged as the end of the chunk also yields a chunk-end marker (kind 3)
// that reports a link left open. A byte is taken every cycle while full is
// low; a byte's work entry is written into the queue and then registered
// into the emitter's output register that drives the result ports. The
// result side gives one beat per cycle while pop is high, so a byte with
// two beats (link result plus chunk end) sends them in turn; the work queue
// of QDepth entries between parser and emitter absorbs bursts and pop stalls.
module anchor_link_extractor import ale_pkg::*; #(
  parameter int QDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // byte input, queue style
  input  logic     push,
  output logic     full,
  input  ale_in_t  in_i,
  // result output, queue style
  output logic     empty,
  input  logic     pop,
  output ale_out_t out_o
);

  // front to queue
  logic      wr_en;
  ale_work_t wr_data;
  // queue to back
  ale_work_t head;
  logic      q_full, q_empty, deq;

  // parser: matches "<a ", "href=" and "/a>" one byte per cycle unless the
  // queue is full; each byte gives at most one link result plus a chunk end
  ale_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data)
  );

  // short work queue decoupling parser from emitter
  ale_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_en_i   (deq),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // emitter: expands each work entry into one or two result beats
  ale_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .deq_o     (deq),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

  // bytes that cause no result never enter the queue, so full only
  // reflects pending work
  assign full = q_full;

endmodule

// File: design/ale_checker.sv
`timescale 1ns / 1ps

module ale_checker import ale_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input ale_out_t out_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("result changed while waiting");

  // chunk end always closes the run of results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.out_kind == KIND_END) |-> out_o.run_last)
    else $error("chunk end without run_last");

  // abandoned flag only on chunk end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.out_kind != KIND_END) |-> !out_o.link_abandoned)
    else $error("abandoned flag on non-end result");

  // markers carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.out_kind == KIND_DONE || out_o.out_kind == KIND_END))
      |-> (out_o.out_byte == 8'd0))
    else $error("marker with nonzero byte");

endmodule

bind anchor_link_extractor ale_checker u_ale_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

// File: dv/anchor_link_extractor_tb.sv
`timescale 1ns / 1ps

import ale_pkg::*;

// tracks the parser state byte by byte and keeps the beats that are still owed
class link_scoreboard;
  localparam logic [39:0] HrefWord = "href=";

  ale_phase_e phase;
  logic [1:0] open_cnt;
  logic [2:0] href_cnt;
  logic [1:0] close_cnt;
  logic       url_on;
  logic       url_done;

  ale_out_t   owed_beats_q[$];
  int         mismatches;
  int         beats_checked;
  int         links_closed;
  int         links_abandoned;

  function new();
    mismatches      = 0;
    beats_checked   = 0;
    links_closed    = 0;
    links_abandoned = 0;
    clear_parser();
  endfunction

  function void clear_parser();
    phase     = PH_SEARCH;
    open_cnt  = 2'd0;
    href_cnt  = 3'd0;
    close_cnt = 2'd0;
    url_on    = 1'b0;
    url_done  = 1'b0;
  endfunction

  function logic [7:0] fold_case(logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function void owe_beat(ale_kind_e kind, logic [7:0] value, logic abandoned);
    ale_out_t r;
    r.out_kind       = kind;
    r.out_byte       = value;
    r.link_abandoned = abandoned;
    r.run_last       = 1'b0;
    owed_beats_q.push_back(r);
  endfunction

  function int pending();
    return owed_beats_q.size();
  endfunction

  // works out the beats that one accepted byte gives
  function void note_byte(ale_in_t beat);
    logic [7:0] b;
    logic [7:0] lb;
    logic       closed;
    int         c;
    int         first_new;
    b         = beat.data_byte;
    lb        = fold_case(b);
    first_new = owed_beats_q.size();
    if (phase == PH_SEARCH) begin
      case (open_cnt)
        2'd0: open_cnt = (b == ChLt) ? 2'd1 : 2'd0;
        2'd1: begin
          if (lb == ChA) open_cnt = 2'd2;
          else open_cnt = (b == ChLt) ? 2'd1 : 2'd0;
        end
        default: begin
          if (b == ChSpace) begin
            clear_parser();
            phase = PH_TAG;
          end else begin
            open_cnt = (b == ChLt) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end else begin
      closed = 1'b0;
      if (close_cnt == 2'd2 && b == ChGt) closed = 1'b1;
      else if (close_cnt == 2'd1 && lb == ChA) close_cnt = 2'd2;
      else close_cnt = (b == ChSlash) ? 2'd1 : 2'd0;

      if (closed) begin
        owe_beat(KIND_DONE, 8'h00, 1'b0);
        links_closed++;
        clear_parser();
      end else if (phase == PH_TAG) begin
        if (url_on) begin
          if (b == ChSpace || b == ChGt) begin
            url_on   = 1'b0;
            url_done = 1'b1;
          end else if (b != ChSq && b != ChDq) begin
            owe_beat(KIND_URL, b, 1'b0);
          end
        end else if (!url_done) begin
          c = int'(href_cnt);
          if (c > 4) c = 0;
          if (lb == HrefWord[8*(4-c) +: 8]) begin
            c++;
            if (c == 5) begin
              url_on = 1'b1;
              c      = 0;
            end
          end else begin
            c = (lb == ChH) ? 1 : 0;
          end
          href_cnt = c[2:0];
        end
        if (b == ChGt) begin
          phase    = PH_TITLE;
          url_on   = 1'b0;
          url_done = 1'b1;
          href_cnt = 3'd0;
        end
      end else if (phase == PH_TITLE) begin
        if (b == ChLt) phase = PH_WAIT;
        else owe_beat(KIND_TITLE, b, 1'b0);
      end
    end

    if (beat.chunk_last) begin
      if (phase != PH_SEARCH) links_abandoned++;
      owe_beat(KIND_END, 8'h00, phase != PH_SEARCH);
      clear_parser();
    end

    if (owed_beats_q.size() > first_new) begin
      owed_beats_q[owed_beats_q.size()-1].run_last = 1'b1;
    end
  endfunction

  function void check_result(ale_out_t got);
    ale_out_t want;
    beats_checked++;
    if (owed_beats_q.size() == 0) begin
      mismatches++;
      $display("%0t: expected no beat, actual kind=%0d byte=%h abandoned=%b last=%b",
               $time, got.out_kind, got.out_byte, got.link_abandoned, got.run_last);
      return;
    end
    want = owed_beats_q.pop_front();
    if (got.out_kind != want.out_kind) begin
      mismatches++;
      $display("%0t: out_kind expected %0d actual %0d", $time, want.out_kind, got.out_kind);
    end
    if (got.out_byte != want.out_byte) begin
      mismatches++;
      $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
    end
    if (got.link_abandoned != want.link_abandoned) begin
      mismatches++;
      $display("%0t: link_abandoned expected %b actual %b", $time,
               want.link_abandoned, got.link_abandoned);
    end
    if (got.run_last != want.run_last) begin
      mismatches++;
      $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
    end
  endfunction
endclass

module anchor_link_extractor_tb;

  // cycles with no beat moving on either side before the run is called hung
  localparam int StallLimit   = 4000;
  localparam int BytesPerPass = 475;
  localparam int DrainCycles  = 16;

  logic     clk;
  logic     rst_ni;
  logic     push;
  logic     full;
  ale_in_t  byte_in;
  logic     empty;
  logic     pop;
  ale_out_t result_out;

  int tx_idle_pct;
  int rx_stall_pct;
  int bytes_sent;
  int chunks_sent;
  int quiet_cycles;

  logic [7:0] chunk_q[$];

  link_scoreboard link_sb;

  anchor_link_extractor u_top (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (byte_in),
    .empty (empty),
    .pop   (pop),
    .out_o (result_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: pop decided at the falling edge, beats checked at the rising edge
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && pop && !empty) begin
      link_sb.check_result(result_out);
    end
  end

  // watchdog: any beat on either side restarts the count
  always @(posedge clk) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles, %0d beats still owed", $time,
                 StallLimit, link_sb.pending());
        $display("anchor_link_extractor_tb: FAIL");
        $finish;
      end
    end
  end

  // one byte beat; idle gaps come before the byte so push is only raised here
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    byte_in = '{data_byte: b, chunk_last: last};
    do @(posedge clk); while (full);
    link_sb.note_byte(byte_in);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk();
    for (int i = 0; i < chunk_q.size(); i++) begin
      send_byte(chunk_q[i], i == chunk_q.size() - 1);
    end
    chunks_sent++;
    chunk_q.delete();
  endtask

  // hold the sender off until the block has handed back everything owed
  task automatic drain();
    push = 1'b0;
    while (link_sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1) == 1) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic void add_text(string s, bit mix);
    for (int i = 0; i < s.len(); i++) begin
      chunk_q.push_back(mix ? any_case(s[i]) : s[i]);
    end
  endfunction

  function automatic logic [7:0] url_char();
    int r;
    r = $urandom_range(19);
    case (r)
      0:       return ChSq;
      1:       return ChDq;
      2:       return ChSlash;
      3:       return "a";
      4:       return "A";
      5:       return "h";
      default: return 8'h30 + 8'($urandom_range(42));  // digits, punctuation, capitals
    endcase
  endfunction

  function automatic logic [7:0] title_char();
    int r;
    r = $urandom_range(15);
    case (r)
      0:       return 8'($urandom_range(255));
      1:       return ChSlash;
      2:       return ChSpace;
      3:       return ChGt;
      default: return "a" + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic void add_href();
    logic [7:0] quote;
    int         r;
    r     = $urandom_range(2);
    quote = (r == 0) ? ChSq : ((r == 1) ? ChDq : 8'h00);
    add_text("href=", 1);
    if (quote != 8'h00) chunk_q.push_back(quote);
    repeat ($urandom_range(8)) chunk_q.push_back(url_char());
    if (quote != 8'h00) chunk_q.push_back(quote);
  endfunction

  // one anchor with random content; most are well formed, some bend the rules
  function automatic void add_link();
    int href_mode;
    int close_mode;
    add_text("<a ", 1);
    if ($urandom_range(4) == 0) add_text("id=k ", 1);
    href_mode = $urandom_range(9);
    if (href_mode < 6) begin
      add_href();
      if ($urandom_range(9) == 0) begin
        // link closed while the url is still being collected
        add_text("/a>", 1);
        return;
      end
      if ($urandom_range(3) == 0) add_text(" rel=x", 1);
    end else if (href_mode == 9) begin
      // near misses: a broken href, and an href right after a doubled h
      if ($urandom_range(1) == 1) add_text("hre=zz ", 1);
      else add_text("hhref=q ", 1);
    end
    chunk_q.push_back(ChGt);
    if (href_mode == 8) add_href();  // after the tag: only title bytes
    repeat ($urandom_range(8)) chunk_q.push_back(title_char());
    close_mode = $urandom_range(9);
    case (close_mode)
      0, 1, 2, 3, 4: add_text("</a>", 1);
      5, 6:          add_text("/a>", 1);  // close without a '<' first
      7:             add_text("<b>x</a>", 1);
      8:             ;                    // left open
      default:       add_text("<a z></a>", 1);  // nested open is ignored
    endcase
  endfunction

  function automatic void build_chunk();
    int links;
    links = $urandom_range(3);
    for (int k = 0; k < links; k++) begin
      if ($urandom_range(1) == 1) begin
        repeat ($urandom_range(4)) chunk_q.push_back(8'($urandom_range(255)));
      end
      add_link();
    end
    if (links == 0 || $urandom_range(3) == 0) begin
      repeat (1 + $urandom_range(5)) chunk_q.push_back(8'($urandom_range(255)));
    end
    // sometimes the chunk ends in the middle of things
    if ($urandom_range(5) == 0 && chunk_q.size() > 1) begin
      chunk_q = chunk_q[0 : $urandom_range(chunk_q.size() - 1)];
    end
  endfunction

  initial begin
    int pass_bytes;
    int pass_chunks;
    link_sb      = new();
    rst_ni       = 1'b0;
    push         = 1'b0;
    byte_in      = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    bytes_sent   = 0;
    chunks_sent  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed: mixed case open and href, quotes dropped, close inside the url,
    // link complete and chunk end on the same byte
    add_text("<A hREF=\"u/a>", 0);
    send_chunk();
    // no href, a title of byte 0xFF, '<' ends the title, nested open and an
    // href after the tag are ignored, chunk ends with the link still open
    add_text("<a x>", 0);
    chunk_q.push_back(8'hFF);
    add_text("<a href=q>", 0);
    chunk_q.push_back(8'h00);
    send_chunk();
    drain();

    // random passes: steady, slow sender, slow receiver, both slow
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      pass_bytes  = bytes_sent;
      pass_chunks = 0;
      while (bytes_sent - pass_bytes < BytesPerPass) begin
        build_chunk();
        // mid-pass the sender waits for the result queue to run dry
        if (pass_chunks == 6) drain();
        send_chunk();
        pass_chunks++;
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d bytes in %0d chunks: %0d result beats checked", bytes_sent,
             chunks_sent, link_sb.beats_checked);
    $display("links closed %0d, links abandoned at chunk end %0d, mismatches %0d",
             link_sb.links_closed, link_sb.links_abandoned, link_sb.mismatches);
    if (link_sb.mismatches == 0 && link_sb.pending() == 0) begin
      $display("anchor_link_extractor_tb: PASS");
    end else begin
      if (link_sb.pending() != 0) $display("%0t: %0d beats never arrived", $time,
                                           link_sb.pending());
      $display("anchor_link_extractor_tb: FAIL");
    end
    $finish;
  end

endmodule
